/* hw/rtl/sync_length_checksum_frame_parser_assert.svh */
// Assertion macros for the sync/length/checksum frame parser.
`ifndef SYNC_LENGTH_CHECKSUM_FRAME_PARSER_ASSERT_SVH
`define SYNC_LENGTH_CHECKSUM_FRAME_PARSER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on i_clk outside reset.
`define SLCFP_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("slcfp assertion failed");
// Next-cycle implication, checked on i_clk outside reset.
`define SLCFP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("slcfp assertion failed");
`else
`define SLCFP_ASSERT_IMPL(lbl, ante, cons)
`define SLCFP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* hw/rtl/slcfp_pkg.sv */
// Shared types and constants for the sync/length/checksum frame parser.
package slcfp_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned CNT_W   = 32;
    localparam int unsigned PAY_N   = 4;
    localparam int unsigned IDX_W   = 2;
    localparam int unsigned ADDR_W  = 3;
    localparam int unsigned APB_W   = 32;

    localparam logic [BYTE_W-1:0] FRAME_LEN  = 8'd4;
    localparam logic [BYTE_W-1:0] SYNC_RESET = 8'hA5;
    localparam logic [IDX_W-1:0]  IDX_LAST   = 2'd3;

    // Register index taken from paddr[2]
    localparam logic REG_SYNC = 1'b0;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_LEN     = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_CHECK   = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_NONE   = 2'd0,
        ST_OK     = 2'd1,
        ST_BADLEN = 2'd2,
        ST_BADCHK = 2'd3
    } t_status;

    typedef struct packed {
        t_status           status;
        logic [WORD_W-1:0] word;
        logic [CNT_W-1:0]  good_count;
        logic [CNT_W-1:0]  bad_checksum_count;
        logic [CNT_W-1:0]  bad_length_count;
    } t_result;

endpackage

/* hw/rtl/slcfp_parser.sv */
// Frame parser state, payload store and counters; one byte per cycle while i_accept is high.
module slcfp_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [slcfp_pkg::BYTE_W-1:0]  i_rx_byte,
    input  logic [slcfp_pkg::BYTE_W-1:0]  i_sync_byte,
    output slcfp_pkg::t_result            o_res
);

    slcfp_pkg::t_phase                r_phase, n_phase;
    logic [slcfp_pkg::IDX_W-1:0]      r_idx, n_idx;
    logic [slcfp_pkg::CNT_W-1:0]      r_good, n_good;
    logic [slcfp_pkg::CNT_W-1:0]      r_badchk, n_badchk;
    logic [slcfp_pkg::CNT_W-1:0]      r_badlen, n_badlen;
    logic [slcfp_pkg::BYTE_W-1:0]     r_payload [slcfp_pkg::PAY_N];
    logic [slcfp_pkg::BYTE_W-1:0]     w_sum;
    logic                             w_pay_we;

    // Checksum over length plus payload, wrapping at 8 bits
    assign w_sum = slcfp_pkg::FRAME_LEN + r_payload[0] + r_payload[1]
                 + r_payload[2] + r_payload[3];

    // Next state, counters and result for the current byte
    always_comb begin
        n_phase  = r_phase;
        n_idx    = r_idx;
        n_good   = r_good;
        n_badchk = r_badchk;
        n_badlen = r_badlen;
        w_pay_we = 1'b0;
        o_res.status = slcfp_pkg::ST_NONE;
        o_res.word   = '0;
        case (r_phase)
            slcfp_pkg::PH_HUNT: begin
                if (i_rx_byte == i_sync_byte) begin
                    n_phase = slcfp_pkg::PH_LEN;
                end
            end
            slcfp_pkg::PH_LEN: begin
                n_idx = '0;
                if (i_rx_byte != slcfp_pkg::FRAME_LEN) begin
                    n_badlen     = r_badlen + 1'b1;
                    n_phase      = slcfp_pkg::PH_HUNT;
                    o_res.status = slcfp_pkg::ST_BADLEN;
                end else begin
                    n_phase = slcfp_pkg::PH_PAYLOAD;
                end
            end
            slcfp_pkg::PH_PAYLOAD: begin
                w_pay_we = 1'b1;
                n_idx    = r_idx + 1'b1;
                if (r_idx == slcfp_pkg::IDX_LAST) begin
                    n_phase = slcfp_pkg::PH_CHECK;
                end
            end
            slcfp_pkg::PH_CHECK: begin
                n_phase = slcfp_pkg::PH_HUNT;
                if (w_sum != i_rx_byte) begin
                    n_badchk     = r_badchk + 1'b1;
                    o_res.status = slcfp_pkg::ST_BADCHK;
                end else begin
                    n_good       = r_good + 1'b1;
                    o_res.status = slcfp_pkg::ST_OK;
                    o_res.word   = {r_payload[3], r_payload[2], r_payload[1], r_payload[0]};
                end
            end
            default: begin
                n_phase = slcfp_pkg::PH_HUNT;
            end
        endcase
        o_res.good_count         = n_good;
        o_res.bad_checksum_count = n_badchk;
        o_res.bad_length_count   = n_badlen;
    end

    // Advance control state on each accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= slcfp_pkg::PH_HUNT;
            r_idx    <= '0;
            r_good   <= '0;
            r_badchk <= '0;
            r_badlen <= '0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_idx    <= n_idx;
            r_good   <= n_good;
            r_badchk <= n_badchk;
            r_badlen <= n_badlen;
        end
    end

    // Store payload bytes; no reset needed
    always_ff @(posedge i_clk) begin
        if (i_accept && w_pay_we) begin
            r_payload[r_idx] <= i_rx_byte;
        end
    end

endmodule

/* hw/rtl/slcfp_skid.sv */
// Output register with a skid stage so the input side can take one more result while the output stalls.
module slcfp_skid (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  slcfp_pkg::t_result   i_res,
    output logic                 o_push_ready,
    output logic                 o_valid,
    input  logic                 i_ready,
    output slcfp_pkg::t_result   o_res
);

    logic               r_out_valid;
    logic               r_skid_valid;
    slcfp_pkg::t_result r_out;
    slcfp_pkg::t_result r_skid;
    logic               w_take;

    assign w_take       = r_out_valid & i_ready;
    assign o_push_ready = ~r_skid_valid;
    assign o_valid      = r_out_valid;
    assign o_res        = r_out;

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || w_take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload: refill from skid first, park new word in skid while stalled
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (i_push) begin
                r_out <= i_res;
            end
        end else if (i_push) begin
            r_skid <= i_res;
        end
    end

endmodule

/* hw/rtl/sync_length_checksum_frame_parser.sv */
// Top level: APB sync register, frame parser and output skid stage.
//
// Usage: received bytes enter on the rx channel (i_rx_valid / o_rx_ready,
// payload i_rx_byte). Every accepted byte yields exactly one result word on
// the result channel (o_res_valid / i_res_ready): a status, the assembled
// little-endian word (zero unless status is OK) and the three
// wrapping 32-bit frame counters as they stand after that byte.
// Each result is registered, straight into the output register or, while
// the output stalls, into the skid stage. Throughput: one byte per cycle
// while the output drains; the output register plus a one-word skid stage
// keep the rx side open while a finished word waits.
// Stall: if the receiver holds i_res_ready low, one more byte is taken into
// the skid stage and then o_rx_ready drops until the output drains.
// Reset (i_rst_n low, synchronous): parser returns to hunting for sync,
// counters clear, both output stages empty, sync byte returns to 0xA5.
// Sync byte at APB address 0; the user must write it only while idle, unenforced.
`include "sync_length_checksum_frame_parser_assert.svh"
module sync_length_checksum_frame_parser (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // APB configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [slcfp_pkg::ADDR_W-1:0]      paddr,
    input  logic [slcfp_pkg::APB_W-1:0]       pwdata,
    output logic [slcfp_pkg::APB_W-1:0]       prdata,
    output logic                              pready,
    // Byte input channel
    input  logic                              i_rx_valid,
    output logic                              o_rx_ready,
    input  logic [7:0]                        i_rx_byte,
    // Result channel
    output logic                              o_res_valid,
    input  logic                              i_res_ready,
    output logic [1:0]                        o_status,
    output logic [31:0]                       o_word,
    output logic [31:0]                       o_good_count,
    output logic [31:0]                       o_bad_checksum_count,
    output logic [31:0]                       o_bad_length_count
);

    logic [slcfp_pkg::BYTE_W-1:0] r_sync_byte;
    logic                         w_cfg_wr;
    logic                         w_push;
    slcfp_pkg::t_result           w_res;
    slcfp_pkg::t_result           w_out;

    // Register write and read-back
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & (paddr[2] == slcfp_pkg::REG_SYNC);
    assign prdata   = (paddr[2] == slcfp_pkg::REG_SYNC)
                    ? {{(slcfp_pkg::APB_W-slcfp_pkg::BYTE_W){1'b0}}, r_sync_byte}
                    : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_byte <= slcfp_pkg::SYNC_RESET;
        end else if (w_cfg_wr) begin
            r_sync_byte <= pwdata[slcfp_pkg::BYTE_W-1:0];
        end
    end

    // Byte handshake
    assign w_push = i_rx_valid & o_rx_ready;

    slcfp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_push),
        .i_rx_byte   (i_rx_byte),
        .i_sync_byte (r_sync_byte),
        .o_res       (w_res)
    );

    slcfp_skid u_skid (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_res        (w_res),
        .o_push_ready (o_rx_ready),
        .o_valid      (o_res_valid),
        .i_ready      (i_res_ready),
        .o_res        (w_out)
    );

    // Drive result fields
    assign o_status             = w_out.status;
    assign o_word               = w_out.word;
    assign o_good_count         = w_out.good_count;
    assign o_bad_checksum_count = w_out.bad_checksum_count;
    assign o_bad_length_count   = w_out.bad_length_count;

    // Checks
    `SLCFP_ASSERT_IMPL(a_word_only_when_ok, o_res_valid && (o_status != slcfp_pkg::ST_OK), o_word == 32'd0)
    `SLCFP_ASSERT_IMPL(a_skid_implies_out, !o_rx_ready, o_res_valid)
    `SLCFP_ASSERT_NEXT(a_push_fills_out, w_push, o_res_valid)

endmodule

/* test/tb_sync_length_checksum_frame_parser.sv */
// Testbench for the sync/length/checksum frame parser: directed and random bytes, scoreboard.
module tb_sync_length_checksum_frame_parser;

    localparam logic [slcfp_pkg::ADDR_W-1:0] ADDR_SYNC   = {slcfp_pkg::REG_SYNC, 2'b00};
    localparam logic [slcfp_pkg::ADDR_W-1:0] ADDR_UNUSED = {~slcfp_pkg::REG_SYNC, 2'b00};
    localparam int HOLD_AFTER = 300;   // results seen before the long receiver hold
    localparam int HOLD_LEN   = 80;

    // Track parser state and the results it owes
    class frame_tracker;
        slcfp_pkg::t_phase   ph;
        logic [7:0]          pay [slcfp_pkg::PAY_N];
        logic [2:0]          idx;
        logic [31:0]         good;
        logic [31:0]         badchk;
        logic [31:0]         badlen;
        logic [7:0]          sync;
        slcfp_pkg::t_result  awaited_results[$];
        int                  errors;

        function new();
            ph = slcfp_pkg::PH_HUNT;
            foreach (pay[i]) pay[i] = '0;
            idx = '0;
            good = '0;
            badchk = '0;
            badlen = '0;
            sync = slcfp_pkg::SYNC_RESET;
            errors = 0;
        endfunction

        function void set_sync(logic [7:0] v);
            sync = v;
        endfunction

        // Advance the frame state by one byte and queue the result it yields
        function void take_byte(logic [7:0] b);
            slcfp_pkg::t_result r;
            logic [7:0]         sum;
            r.status = slcfp_pkg::ST_NONE;
            r.word = '0;
            case (ph)
                slcfp_pkg::PH_HUNT: begin
                    if (b == sync) ph = slcfp_pkg::PH_LEN;
                end
                slcfp_pkg::PH_LEN: begin
                    idx = '0;
                    if (b != slcfp_pkg::FRAME_LEN) begin
                        badlen = badlen + 32'd1;
                        ph = slcfp_pkg::PH_HUNT;
                        r.status = slcfp_pkg::ST_BADLEN;
                    end else begin
                        ph = slcfp_pkg::PH_PAYLOAD;
                    end
                end
                slcfp_pkg::PH_PAYLOAD: begin
                    pay[idx[1:0]] = b;
                    idx = idx + 3'd1;
                    if (idx >= 3'(slcfp_pkg::PAY_N)) ph = slcfp_pkg::PH_CHECK;
                end
                default: begin
                    ph = slcfp_pkg::PH_HUNT;
                    sum = slcfp_pkg::FRAME_LEN + pay[0] + pay[1] + pay[2] + pay[3];
                    if (sum != b) begin
                        badchk = badchk + 32'd1;
                        r.status = slcfp_pkg::ST_BADCHK;
                    end else begin
                        r.word = {pay[3], pay[2], pay[1], pay[0]};
                        good = good + 32'd1;
                        r.status = slcfp_pkg::ST_OK;
                    end
                end
            endcase
            r.good_count = good;
            r.bad_checksum_count = badchk;
            r.bad_length_count = badlen;
            awaited_results.push_back(r);
        endfunction

        // Compare one delivered result with the oldest awaited one
        function void match_result(slcfp_pkg::t_result act);
            slcfp_pkg::t_result exp;
            if (awaited_results.size() == 0) begin
                $error("result word delivered with no byte pending");
                errors++;
                return;
            end
            exp = awaited_results.pop_front();
            if (act.status !== exp.status) begin
                $error("status: expected %0d, got %0d", exp.status, act.status);
                errors++;
            end
            if (act.word !== exp.word) begin
                $error("word: expected %h, got %h", exp.word, act.word);
                errors++;
            end
            if (act.good_count !== exp.good_count) begin
                $error("good_count: expected %0d, got %0d", exp.good_count, act.good_count);
                errors++;
            end
            if (act.bad_checksum_count !== exp.bad_checksum_count) begin
                $error("bad_checksum_count: expected %0d, got %0d",
                       exp.bad_checksum_count, act.bad_checksum_count);
                errors++;
            end
            if (act.bad_length_count !== exp.bad_length_count) begin
                $error("bad_length_count: expected %0d, got %0d",
                       exp.bad_length_count, act.bad_length_count);
                errors++;
            end
        endfunction
    endclass

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [slcfp_pkg::ADDR_W-1:0]     paddr;
    logic [slcfp_pkg::APB_W-1:0]      pwdata;
    logic [slcfp_pkg::APB_W-1:0]      prdata;
    logic                             pready;
    logic                             i_rx_valid;
    logic                             o_rx_ready;
    logic [7:0]                       i_rx_byte;
    logic                             o_res_valid;
    logic                             i_res_ready;
    logic [1:0]                       o_status;
    logic [31:0]                      o_word;
    logic [31:0]                      o_good_count;
    logic [31:0]                      o_bad_checksum_count;
    logic [31:0]                      o_bad_length_count;

    frame_tracker tracker;
    bit           idling_on;
    int           results_seen;

    sync_length_checksum_frame_parser i_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready),
        .i_rx_valid           (i_rx_valid),
        .o_rx_ready           (o_rx_ready),
        .i_rx_byte            (i_rx_byte),
        .o_res_valid          (o_res_valid),
        .i_res_ready          (i_res_ready),
        .o_status             (o_status),
        .o_word               (o_word),
        .o_good_count         (o_good_count),
        .o_bad_checksum_count (o_bad_checksum_count),
        .o_bad_length_count   (o_bad_length_count)
    );

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop if the run hangs
    initial begin
        #400000;
        $display("CHECK FAILED");
        $finish;
    end

    // Sink results: check each accepted word, stall in random bursts
    initial begin
        slcfp_pkg::t_result act;
        int                 stall_left;
        bit                 long_hold_done;
        stall_left = 0;
        long_hold_done = 1'b0;
        results_seen = 0;
        i_res_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_res_valid && i_res_ready) begin
                act.status = slcfp_pkg::t_status'(o_status);
                act.word = o_word;
                act.good_count = o_good_count;
                act.bad_checksum_count = o_bad_checksum_count;
                act.bad_length_count = o_bad_length_count;
                tracker.match_result(act);
                results_seen++;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_res_ready <= 1'b0;
            end else if (!long_hold_done && results_seen >= HOLD_AFTER) begin
                // hold off long enough for the input side to back up
                long_hold_done = 1'b1;
                stall_left = HOLD_LEN - 1;
                i_res_ready <= 1'b0;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 14) - 1;
                i_res_ready <= 1'b0;
            end else begin
                i_res_ready <= 1'b1;
            end
        end
    end

    // Offer one byte, with an optional idle burst first; return once accepted
    task automatic send_byte(input logic [7:0] b);
        if (idling_on && $urandom_range(0, 4) == 0) begin
            i_rx_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (!o_rx_ready);
        tracker.take_byte(b);
    endtask

    // APB write: setup cycle, then access cycle
    task automatic apb_write(input logic [slcfp_pkg::ADDR_W-1:0] addr,
                             input logic [slcfp_pkg::APB_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_SYNC) tracker.set_sync(data[7:0]);
    endtask

    // Read back the sync register and compare
    task automatic check_sync_readback();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= ADDR_SYNC;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[7:0] !== tracker.sync) begin
            $error("sync_byte: expected %h, got %h", tracker.sync, prdata[7:0]);
            tracker.errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Wait until every awaited result is in, plus a short margin
    task automatic drain();
        while (tracker.awaited_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_payload();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Mostly well-formed frames with random content, some broken ones and noise
    task automatic send_frame_mix(input int n_bytes);
        int         sent;
        int         kind;
        logic [7:0] p [slcfp_pkg::PAY_N];
        logic [7:0] sum;
        logic [7:0] len;
        sent = 0;
        while (sent < n_bytes) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                // noise while hunting
                send_byte(8'($urandom));
                sent += 1;
            end else if (kind == 1) begin
                // sync followed by a wrong length, sometimes the sync value itself
                len = ($urandom_range(0, 2) == 0) ? tracker.sync : 8'($urandom);
                if (len == slcfp_pkg::FRAME_LEN) len = len + 8'd1;
                send_byte(tracker.sync);
                send_byte(len);
                sent += 2;
            end else begin
                foreach (p[i]) p[i] = pick_payload();
                sum = slcfp_pkg::FRAME_LEN + p[0] + p[1] + p[2] + p[3];
                send_byte(tracker.sync);
                send_byte(slcfp_pkg::FRAME_LEN);
                foreach (p[i]) send_byte(p[i]);
                if ($urandom_range(0, 3) == 0) send_byte(8'($urandom));
                else send_byte(sum);
                sent += 7;
            end
        end
    endtask

    // Stimulus and end of run
    initial begin
        logic [7:0] directed [$];
        logic [7:0] sync_vals [$];
        tracker = new();
        directed = '{
            // good frame, all-zero payload
            8'hA5, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h04,
            // good frame, all-ones payload, checksum wraps to zero
            8'hA5, 8'h04, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00,
            // sync value in the length slot
            8'hA5, 8'hA5,
            // largest length
            8'hA5, 8'hFF,
            // checksum mismatch
            8'hA5, 8'h04, 8'h12, 8'h34, 8'h56, 8'h78, 8'hFF
        };
        sync_vals = '{8'h00, 8'hFF, 8'h04, 8'($urandom), 8'($urandom),
                      slcfp_pkg::SYNC_RESET};
        idling_on = 1'b1;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_rx_valid = 1'b0;
        i_rx_byte = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed bytes at the reset sync value
        check_sync_readback();
        foreach (directed[i]) send_byte(directed[i]);
        i_rx_valid <= 1'b0;
        drain();

        // random phases, one sync setting each
        foreach (sync_vals[k]) begin
            apb_write(ADDR_SYNC, {24'($urandom), sync_vals[k]});
            if (k == 3) apb_write(ADDR_UNUSED, 32'($urandom));
            check_sync_readback();
            if (k == sync_vals.size() - 1) idling_on = 1'b0;
            else idling_on = ($urandom_range(0, 3) != 0);
            send_frame_mix(115);
            i_rx_valid <= 1'b0;
            drain();
        end

        repeat (6) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.awaited_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/slcfp_pkg.sv
hw/rtl/slcfp_parser.sv
hw/rtl/slcfp_skid.sv
hw/rtl/sync_length_checksum_frame_parser.sv
test/tb_sync_length_checksum_frame_parser.sv
